// ----- hdl/biquad_cascade_iir_filter_defines.svh -----
// Assertion macros for the biquad cascade filter.
`ifndef BIQUAD_CASCADE_IIR_FILTER_DEFINES_SVH
`define BIQUAD_CASCADE_IIR_FILTER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define BQIIR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define BQIIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/bqiir_pkg.sv -----
// Constants, codes and helper functions for the biquad cascade filter.
`timescale 1ns / 1ps

package bqiir_pkg;

   localparam int MAX_SECTIONS = 8;
   localparam int SAMPLE_BITS  = 24;
   localparam int COEF_BITS    = 32;
   localparam int DELAY_BITS   = 40;
   localparam int DELAY_FRAC   = 31;
   localparam int COEF_FRAC    = COEF_BITS - 4;
   localparam int IN_SHIFT     = DELAY_FRAC - (SAMPLE_BITS - 1);
   localparam int NUM_COEFS    = 5;

   localparam int OP_W      = 2;
   localparam int SEL_W     = 3;
   localparam int SEC_IN_W  = 3;
   localparam int CSR_W     = 4;
   localparam int TERM_W    = 3;

   localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W      = $clog2(MAX_SECTIONS + 1);
   localparam int COEF_DEPTH = MAX_SECTIONS * NUM_COEFS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int DLY_AW     = SEC_W + 2;
   localparam int DLY_DEPTH  = 1 << DLY_AW;

   localparam int LO_BITS = DELAY_BITS / 2;
   localparam int HI_BITS = DELAY_BITS - LO_BITS;
   localparam int PROD_W  = COEF_BITS + DELAY_BITS;
   localparam int ACC_W   = DELAY_BITS + 8;
   localparam int RND_W   = DELAY_BITS + 1 - IN_SHIFT;

   typedef enum logic [OP_W-1:0] {
      OP_FILTER     = 2'd0,
      OP_WRITE_COEF = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   localparam logic [SEL_W-1:0] SEL_B0 = 3'd0;
   localparam logic [SEL_W-1:0] SEL_B1 = 3'd1;
   localparam logic [SEL_W-1:0] SEL_B2 = 3'd2;
   localparam logic [SEL_W-1:0] SEL_A1 = 3'd3;
   localparam logic [SEL_W-1:0] SEL_A2 = 3'd4;

   // Order of the products within one section.
   localparam logic [TERM_W-1:0] TERM_A1 = 3'd0;
   localparam logic [TERM_W-1:0] TERM_A2 = 3'd1;
   localparam logic [TERM_W-1:0] TERM_B0 = 3'd2;
   localparam logic [TERM_W-1:0] TERM_B1 = 3'd3;
   localparam logic [TERM_W-1:0] TERM_B2 = 3'd4;

   localparam logic signed [COEF_BITS-1:0] COEF_ONE =
      {{(COEF_BITS-COEF_FRAC){1'b0}}, {COEF_FRAC{1'b0}}} | (COEF_BITS'(1) << COEF_FRAC);

   function automatic logic [SEL_W-1:0] term_coef_sel(input logic [TERM_W-1:0] term);
      logic [SEL_W-1:0] sel;
      case (term)
         TERM_A1: sel = SEL_A1;
         TERM_A2: sel = SEL_A2;
         TERM_B0: sel = SEL_B0;
         TERM_B1: sel = SEL_B1;
         TERM_B2: sel = SEL_B2;
         default: sel = SEL_B0;
      endcase
      return sel;
   endfunction

   function automatic logic signed [DELAY_BITS-1:0] sat_delay(
      input logic signed [ACC_W-1:0] v);
      logic [ACC_W-DELAY_BITS:0] top;
      logic signed [DELAY_BITS-1:0] r;
      top = v[ACC_W-1:DELAY_BITS-1];
      if (top == '0 || top == '1) begin
         r = v[DELAY_BITS-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(DELAY_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(DELAY_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [RND_W-1:0] v);
      logic [RND_W-SAMPLE_BITS:0] top;
      logic signed [SAMPLE_BITS-1:0] r;
      top = v[RND_W-1:SAMPLE_BITS-1];
      if (top == '0 || top == '1) begin
         r = v[SAMPLE_BITS-1:0];
      end else if (v[RND_W-1]) begin
         r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ----- hdl/biquad_cascade_iir_filter.sv -----
// Top level of the two-channel cascaded biquad IIR filter.
//
// req_* takes one item per handshake: filter a sample, write one coefficient,
// or clear every delay word. A filtered sample comes back on rsp_* with its
// channel; the other operations give no result. csr_* writes the number of
// sections in use (values above eight act as eight); it is always ready.
// One multiply-accumulate unit does all the arithmetic: each product passes
// through operand read, low half, high half and accumulate steps, five
// products per section, plus steps to store the node and pass the output on.
// rsp_valid rises when a filter item leaves its final step, and req_ready
// returns in the same cycle. Coefficient writes, clears and unused codes
// finish as they are accepted and leave req_ready high.
// The result waits in an output register, so the next item is accepted while
// the receiver stalls; a second result waits in its final step until the
// register is free. Reset restores b0 = 1.0 with all other coefficients
// zero, clears all delay words and sets zero sections in use (pass-through).
`timescale 1ns / 1ps
`include "biquad_cascade_iir_filter_defines.svh"

module biquad_cascade_iir_filter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [bqiir_pkg::OP_W-1:0]              req_operation,
   input  logic                                    req_channel,
   input  logic signed [bqiir_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic [bqiir_pkg::SEC_IN_W-1:0]          req_section_index,
   input  logic [bqiir_pkg::SEL_W-1:0]             req_coef_select,
   input  logic signed [bqiir_pkg::COEF_BITS-1:0]  req_coef_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [bqiir_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                    rsp_channel_out,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [bqiir_pkg::CSR_W-1:0]             csr_data
);

   import bqiir_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_READ   = 8'b0000_0010,
      ST_MUL_LO = 8'b0000_0100,
      ST_MUL_HI = 8'b0000_1000,
      ST_ACC    = 8'b0001_0000,
      ST_NODE   = 8'b0010_0000,
      ST_NEXT   = 8'b0100_0000,
      ST_FIN    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [CSR_W-1:0] sections_ff, sections_in;
   logic [CNT_W-1:0] nsec_ff, nsec_in;
   logic [SEC_W-1:0] sec_ff, sec_in;
   logic [TERM_W-1:0] term_ff, term_in;
   logic chan_ff, chan_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [COEF_BITS-1:0] coef_ff, coef_in;
   logic signed [DELAY_BITS-1:0] opnd_ff, opnd_in;
   logic signed [DELAY_BITS-1:0] w_ff, w_in;
   logic signed [DELAY_BITS-1:0] w1_ff, w1_in;
   logic signed [DELAY_BITS-1:0] w2_ff, w2_in;
   logic dvld_ff, cvld_ff, cb0_ff;
   logic [COEF_DEPTH-1:0] coef_vld_ff, coef_vld_in;
   logic [DLY_DEPTH-1:0] dly_vld_ff, dly_vld_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic rsp_chan_ff, rsp_chan_in;

   logic coef_we;
   logic [COEF_AW-1:0] coef_waddr, coef_raddr;
   logic [COEF_BITS-1:0] coef_q;
   logic dly_we;
   logic [DLY_AW-1:0] dly_waddr, dly_raddr;
   logic signed [DELAY_BITS-1:0] dly_wdata;
   logic [DELAY_BITS-1:0] dly_q;

   logic req_fire;
   logic [CNT_W-1:0] nsec_eff;
   logic signed [COEF_BITS-1:0] coef_eff;
   logic signed [DELAY_BITS-1:0] opnd_sel;
   logic signed [COEF_BITS-1:0] mul_a;
   logic signed [HI_BITS:0] mul_b;
   logic signed [COEF_BITS+HI_BITS:0] mul_p;
   logic signed [ACC_W-1:0] term_val;
   logic signed [DELAY_BITS:0] biased;
   logic last_sec;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_channel_out = rsp_chan_ff;

   assign nsec_eff = (int'(sections_ff) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS)
                                                        : CNT_W'(sections_ff);
   assign coef_waddr = COEF_AW'(int'(req_section_index) * NUM_COEFS + int'(req_coef_select));
   assign coef_raddr = COEF_AW'(int'(sec_ff) * NUM_COEFS + int'(term_coef_sel(term_ff)));
   assign dly_raddr  = {sec_ff, chan_ff, (term_ff == TERM_A2)};
   assign last_sec   = ((CNT_W'(sec_ff) + CNT_W'(1)) == nsec_ff);

   assign coef_eff = cvld_ff ? $signed(coef_q) : (cb0_ff ? COEF_ONE : '0);

   always_comb begin
      case (term_ff)
         TERM_A1, TERM_A2: opnd_sel = dvld_ff ? $signed(dly_q) : '0;
         TERM_B0:          opnd_sel = w_ff;
         TERM_B1:          opnd_sel = w1_ff;
         TERM_B2:          opnd_sel = w2_ff;
         default:          opnd_sel = '0;
      endcase
   end

   assign mul_a    = (state_ff == ST_MUL_HI) ? coef_ff : coef_eff;
   assign mul_b    = (state_ff == ST_MUL_HI)
                     ? $signed({opnd_ff[DELAY_BITS-1], opnd_ff[DELAY_BITS-1:LO_BITS]})
                     : $signed({{(HI_BITS-LO_BITS+1){1'b0}}, opnd_sel[LO_BITS-1:0]});
   assign mul_p    = mul_a * mul_b;
   assign term_val = ACC_W'(prod_ff >>> COEF_FRAC);
   assign biased   = (DELAY_BITS+1)'($signed(acc_ff[DELAY_BITS-1:0]))
                     + ((DELAY_BITS+1)'(1) <<< (IN_SHIFT - 1));

   always_comb begin
      state_in      = state_ff;
      sections_in   = sections_ff;
      nsec_in       = nsec_ff;
      sec_in        = sec_ff;
      term_in       = term_ff;
      chan_in       = chan_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      coef_in       = coef_ff;
      opnd_in       = opnd_ff;
      w_in          = w_ff;
      w1_in         = w1_ff;
      w2_in         = w2_ff;
      coef_vld_in   = coef_vld_ff;
      dly_vld_in    = dly_vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      coef_we       = 1'b0;
      dly_we        = 1'b0;
      dly_waddr     = dly_raddr;
      dly_wdata     = w_ff;

      if (csr_valid && csr_ready) begin
         sections_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (op_type'(req_operation))
                  OP_FILTER: begin
                     chan_in  = req_channel;
                     acc_in   = ACC_W'(req_sample_in) <<< IN_SHIFT;
                     sec_in   = '0;
                     term_in  = TERM_A1;
                     nsec_in  = nsec_eff;
                     state_in = (nsec_eff == '0) ? ST_FIN : ST_READ;
                  end
                  OP_WRITE_COEF: begin
                     if (int'(req_section_index) < MAX_SECTIONS && req_coef_select <= SEL_A2)
                     begin
                        coef_we                 = 1'b1;
                        coef_vld_in[coef_waddr] = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     dly_vld_in = '0;
                  end
                  OP_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            // store w into the first delay word once both old words are held
            if (term_ff == TERM_B0) begin
               dly_we                = 1'b1;
               dly_waddr             = {sec_ff, chan_ff, 1'b0};
               dly_wdata             = w_ff;
               dly_vld_in[dly_waddr] = 1'b1;
            end
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            prod_in = PROD_W'(mul_p);
            coef_in = coef_eff;
            opnd_in = opnd_sel;
            if (term_ff == TERM_A1) begin
               w1_in = opnd_sel;
            end
            if (term_ff == TERM_A2) begin
               w2_in = opnd_sel;
            end
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_in  = prod_ff + (PROD_W'(mul_p) <<< LO_BITS);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (term_ff == TERM_A1 || term_ff == TERM_A2) begin
               acc_in = acc_ff - term_val;
            end else begin
               acc_in = acc_ff + term_val;
            end
            case (term_ff)
               TERM_A1: begin
                  term_in  = TERM_A2;
                  state_in = ST_READ;
               end
               TERM_A2: begin
                  state_in = ST_NODE;
               end
               TERM_B0: begin
                  term_in  = TERM_B1;
                  state_in = ST_READ;
               end
               TERM_B1: begin
                  term_in  = TERM_B2;
                  state_in = ST_READ;
               end
               default: begin
                  state_in = ST_NEXT;
               end
            endcase
         end
         ST_NODE: begin
            w_in                  = sat_delay(acc_ff);
            acc_in                = '0;
            dly_we                = 1'b1;
            dly_waddr             = {sec_ff, chan_ff, 1'b1};
            dly_wdata             = w1_ff;
            dly_vld_in[dly_waddr] = 1'b1;
            term_in               = TERM_B0;
            state_in              = ST_READ;
         end
         ST_NEXT: begin
            acc_in  = ACC_W'(sat_delay(acc_ff));
            term_in = TERM_A1;
            if (last_sec) begin
               state_in = ST_FIN;
            end else begin
               sec_in   = sec_ff + SEC_W'(1);
               state_in = ST_READ;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat_sample(RND_W'(biased >>> IN_SHIFT));
               rsp_chan_in   = chan_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sections_ff  <= '0;
         coef_vld_ff  <= '0;
         dly_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sections_ff  <= sections_in;
         coef_vld_ff  <= coef_vld_in;
         dly_vld_ff   <= dly_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nsec_ff       <= nsec_in;
      sec_ff        <= sec_in;
      term_ff       <= term_in;
      chan_ff       <= chan_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      coef_ff       <= coef_in;
      opnd_ff       <= opnd_in;
      w_ff          <= w_in;
      w1_ff         <= w1_in;
      w2_ff         <= w2_in;
      dvld_ff       <= dly_vld_ff[dly_raddr];
      cvld_ff       <= coef_vld_ff[coef_raddr];
      cb0_ff        <= (term_coef_sel(term_ff) == SEL_B0);
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
   end

   bqiir_ram #(
      .WIDTH(COEF_BITS),
      .DEPTH(COEF_DEPTH)
   ) u_coef_ram (
      .clock  (clock),
      .wr_en  (coef_we),
      .wr_addr(coef_waddr),
      .wr_data(req_coef_value),
      .rd_addr(coef_raddr),
      .rd_data(coef_q)
   );

   bqiir_ram #(
      .WIDTH(DELAY_BITS),
      .DEPTH(DLY_DEPTH)
   ) u_delay_ram (
      .clock  (clock),
      .wr_en  (dly_we),
      .wr_addr(dly_waddr),
      .wr_data(dly_wdata),
      .rd_addr(dly_raddr),
      .rd_data(dly_q)
   );

   `BQIIR_ASSERT_NEXT(a_busy_after_filter, clock, reset,
      req_fire && req_operation == OP_FILTER, !req_ready, "filter item left the block ready")
   `BQIIR_ASSERT_NOW(a_coef_write_idle, clock, reset,
      coef_we, state_ff == ST_IDLE, "coefficient written while filtering")
   `BQIIR_ASSERT_NOW(a_delay_write_busy, clock, reset,
      dly_we, state_ff == ST_READ || state_ff == ST_NODE, "delay word written outside a step")
   `BQIIR_ASSERT_NOW(a_rsp_from_fin, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff) == ST_FIN, "item presented without a final step")

endmodule

// ----- hdl/bqiir_ram.sv -----
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bqiir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
